// ----- hw/rtl/tcr_pkg.sv -----
package tcr_pkg;

	// ramp length in ms and full-scale torque (Q1.15)
	localparam int unsigned RAMP_MS    = 1000;
	localparam int unsigned FULL_SCALE = 32768;

	localparam logic [15:0] HOLD_RESET = 16'd50;

	// d * 2^15 / RAMP_MS by reciprocal: exact for d < RAMP_MS when
	// 2^RECIP_SHIFT >= RAMP_MS^2 * 2^15
	localparam int RAMP_W      = $clog2(RAMP_MS + 1);
	localparam int RAMP_LOG    = $clog2(RAMP_MS);
	localparam int DIV_SHIFT   = 2 * RAMP_LOG;
	localparam int RECIP_SHIFT = 15 + DIV_SHIFT;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(RAMP_MS) - 64'd1) / 64'(RAMP_MS);
	localparam int RECIP_W     = RECIP_SHIFT - RAMP_LOG + 1;
	localparam int PROD_W      = RAMP_W + RECIP_W;

	typedef struct packed {
		logic        cut;
		logic [31:0] ramp_start;
	} tcr_ctl_t;

endpackage

// ----- hw/rtl/tcr_ifs.sv -----
interface tcr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] slip_meas;
	logic [15:0] slip_allow;
	logic [31:0] time_ms;

	modport source (output valid, slip_meas, slip_allow, time_ms, input ready);
	modport sink   (input valid, slip_meas, slip_allow, time_ms, output ready);
endinterface

interface tcr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] torque_scale;
	logic        torque_cut;

	modport source (output valid, torque_scale, torque_cut, input ready);
	modport sink   (input valid, torque_scale, torque_cut, output ready);
endinterface

// ----- hw/rtl/tcr_state.sv -----
module tcr_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [15:0]      hold_limit,
	input  logic [15:0]      slip_meas,
	input  logic [15:0]      slip_allow,
	input  logic [31:0]      now,
	output tcr_pkg::tcr_ctl_t ctl
);

	logic        slipping_q;
	logic [31:0] slip_change_q;
	logic [31:0] ramp_start_q;

	logic        now_slip;
	logic [31:0] change_time;
	logic [31:0] held;
	logic        cut;

	always_comb begin
		now_slip    = slip_meas > slip_allow;
		change_time = (now_slip != slipping_q) ? now : slip_change_q;
		held        = now - change_time;
		// held is not used while not slipping: cut only for a zero limit
		if (now_slip) begin
			cut = !held[31] && (held >= {16'd0, hold_limit});
		end else begin
			cut = (hold_limit == 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slipping_q    <= 1'b0;
			slip_change_q <= '0;
			ramp_start_q  <= 32'd0 - 32'(tcr_pkg::RAMP_MS);
		end else if (step) begin
			slipping_q    <= now_slip;
			slip_change_q <= change_time;
			if (cut) begin
				ramp_start_q <= now;
			end
		end
	end

	assign ctl.cut        = cut;
	assign ctl.ramp_start = ramp_start_q;

endmodule

// ----- hw/rtl/tcr_ramp.sv -----
module tcr_ramp (
	input  logic [31:0] now,
	input  logic [31:0] ramp_start,
	output logic [15:0] scale
);

	logic [31:0]                  diff;
	logic [tcr_pkg::PROD_W-1:0]   prod;

	always_comb begin
		diff = now - ramp_start;
		prod = tcr_pkg::PROD_W'(diff[tcr_pkg::RAMP_W-1:0])
			* tcr_pkg::PROD_W'(tcr_pkg::RECIP);
		if (diff[31] || diff == 32'd0) begin
			scale = '0;
		end else if (diff >= 32'(tcr_pkg::RAMP_MS)) begin
			scale = 16'(tcr_pkg::FULL_SCALE);
		end else begin
			scale = {1'b0, prod[tcr_pkg::DIV_SHIFT +: 15]};
		end
	end

endmodule

// ----- hw/rtl/traction_cut_and_ramp_unit.sv -----
// Path: a tick beat passes the input register, then the result register.
// Throughput: one tick per cycle unless a result stalls; the slip/ramp state commits as each beat advances.
// Output register decouples sides; tick.ready drops only while a result stalls.
// Reset (arst_n low, async): not slipping, change time 0, ramp complete at
// time zero, hold limit 50 ms, both pipeline registers empty.
module traction_cut_and_ramp_unit (
	input  logic        clk,
	input  logic        arst_n,
	tcr_in_if.sink      tick,
	tcr_out_if.source   result,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	// hold limit register
	logic [15:0] hold_limit_q;

	// input stage
	logic        valid_s1;
	logic [15:0] actual_s1;
	logic [15:0] target_s1;
	logic [31:0] time_s1;

	// result register
	logic        out_valid_q;
	logic [15:0] scale_q;
	logic        cut_q;

	logic              advance;
	tcr_pkg::tcr_ctl_t ctl;
	logic [15:0]       ramp_scale;

	// stage 1 moves on when the result slot is free or being drained
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_limit_q <= tcr_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			hold_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			actual_s1 <= tick.slip_meas;
			target_s1 <= tick.slip_allow;
			time_s1   <= tick.time_ms;
		end
	end

	// slip tracking and cut decision; state commits when the beat advances
	tcr_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.hold_limit  (hold_limit_q),
		.slip_meas   (actual_s1),
		.slip_allow  (target_s1),
		.now         (time_s1),
		.ctl         (ctl)
	);

	// linear re-ramp from the last cut time
	tcr_ramp u_ramp (
		.now        (time_s1),
		.ramp_start (ctl.ramp_start),
		.scale      (ramp_scale)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scale_q <= ctl.cut ? 16'd0 : ramp_scale;
			cut_q   <= ctl.cut;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.torque_scale = scale_q;
	assign result.torque_cut   = cut_q;

`ifndef SYNTHESIS
	a_cut_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && cut_q |-> scale_q == 16'd0)
		else $error("cut beat with nonzero scale");

	a_scale_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> scale_q <= 16'(tcr_pkg::FULL_SCALE))
		else $error("scale above full");

	a_ramp_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.cut |=> ctl.ramp_start == $past(time_s1))
		else $error("ramp did not restart on cut");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(time_s1))
		else $error("stage 1 lost a stalled beat");
`endif

endmodule
